FILE: rtl/bgr_pkg.sv
package bgr_pkg;

  localparam int DefMaxSourceColumns = 256;
  localparam int DefMaxSourceRows    = 256;
  localparam int DefSampleWidth      = 32;

  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth  = 20;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_SOURCE_COLUMNS = 3'd0,
    REG_SOURCE_ROWS    = 3'd1,
    REG_TARGET_COLUMNS = 3'd2,
    REG_TARGET_ROWS    = 3'd3,
    REG_COLUMN_RATIO   = 3'd4,
    REG_ROW_RATIO      = 3'd5
  } cfg_reg_t;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam int PosWidth  = 32;  // (2t+1)*ratio < 2^31
  localparam int FracWidth = 18;  // q1.17, up to 1.0
  localparam int IdxWidth  = 13;  // neighbor index, counts up to 4096
  localparam logic [FracWidth-1:0] FracOne = 18'h20000;
  localparam logic [PosWidth-1:0]  HalfPos = 32'h0001_0000;

  // axis locate result
  typedef struct packed {
    logic [IdxWidth-1:0]  idx;
    logic [FracWidth-1:0] frac;
  } axis_loc_t;

endpackage

FILE: rtl/bilinear_grid_resampler_unit.sv
// bilinear grid resampler
// s_axis carries loads and queries: tuser is the command (0 load, 1 query).
// a load writes a sample into the source store and gives no result; a query
// gives one result item on m_axis: the interpolated sample, and tuser set
// when the cell lies beyond the target size (value zero then).
// cfg writes one register per handshake; write only while the block is idle.
// pipeline: 8 stages: position multiply, index/fraction select, neighbor
// address and store write, four banked store reads (upper and lower pair,
// each split even/odd), column blend products, column blend rounding, row
// blend product, row blend rounding into the output register.
// throughput one item per cycle; the whole pipe advances when the output
// register is empty or taken, so a stall on m_axis freezes every stage and
// s_axis tready drops; nothing is lost or repeated.
// reset clears the config to its reset values and all valid bits, and holds
// s_axis tready and cfg ready low; the store holds no reset value and must
// be loaded before it is read.
// loads write the store in the stage that issues the reads, so later queries
// see them and earlier ones do not.
module bilinear_grid_resampler_unit #(
  parameter int MAX_SOURCE_COLUMNS = bgr_pkg::DefMaxSourceColumns,
  parameter int MAX_SOURCE_ROWS    = bgr_pkg::DefMaxSourceRows,
  parameter int SAMPLE_WIDTH       = bgr_pkg::DefSampleWidth
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // source_address[15:0], sample_value[47:16], target_column[57:48],
  // target_row[67:58], zero fill to 72
  input  logic [71:0]                       s_axis_tdata,
  input  logic                              s_axis_tuser,   // command
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [31:0]                       m_axis_tdata,   // interpolated_value
  output logic                              m_axis_tuser,   // outside_target
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bgr_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [bgr_pkg::CfgDataWidth-1:0]  cfg_data
);
  import bgr_pkg::*;

  localparam int Depth  = MAX_SOURCE_COLUMNS * MAX_SOURCE_ROWS;
  localparam int AW     = $clog2(Depth);
  localparam int SW     = SAMPLE_WIDTH;
  localparam int IW     = IdxWidth;
  localparam logic signed [SW:0] SatHi = (SW+1)'({1'b0, {(SW-1){1'b1}}});
  localparam logic signed [SW:0] SatLo = -SatHi - (SW+1)'(1);

  // configuration
  logic [8:0]  src_cols, src_rows;
  logic [10:0] tgt_cols, tgt_rows;
  logic [19:0] col_ratio, row_ratio;
  logic [IW-1:0] cols_c, rows_c;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_cols  <= 9'd256;
      src_rows  <= 9'd256;
      tgt_cols  <= 11'd256;
      tgt_rows  <= 11'd256;
      col_ratio <= 20'd65536;
      row_ratio <= 20'd65536;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_SOURCE_COLUMNS: src_cols  <= cfg_data[8:0];
        REG_SOURCE_ROWS:    src_rows  <= cfg_data[8:0];
        REG_TARGET_COLUMNS: tgt_cols  <= cfg_data[10:0];
        REG_TARGET_ROWS:    tgt_rows  <= cfg_data[10:0];
        REG_COLUMN_RATIO:   col_ratio <= cfg_data;
        REG_ROW_RATIO:      row_ratio <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (src_cols < 9'd2) cols_c = IW'(2);
    else if (IW'(src_cols) > IW'(MAX_SOURCE_COLUMNS)) cols_c = IW'(MAX_SOURCE_COLUMNS);
    else cols_c = IW'(src_cols);
    if (src_rows < 9'd2) rows_c = IW'(2);
    else if (IW'(src_rows) > IW'(MAX_SOURCE_ROWS)) rows_c = IW'(MAX_SOURCE_ROWS);
    else rows_c = IW'(src_rows);
  end

  // pipeline control
  logic [7:0] vld;
  logic       adv;
  logic       cmd1, cmd2, cmd3, cmd4, cmd5, cmd6, cmd7, cmd8;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv && !rst;
  // loads finish with no result: valid at the output only for queries
  assign m_axis_tvalid = vld[7] && cmd8 == CMD_QUERY;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[6:0], s_axis_tvalid};
  end

  // stage 1 and 2: locate (inside submodules), side data follows
  logic        out1, out2, out3, out4, out5;
  logic [15:0] addr1, addr2;
  logic signed [31:0] val1, val2;
  axis_loc_t   cloc, rloc;

  bgr_locate u_col (
    .clk(clk), .en(adv), .t(s_axis_tdata[57:48]), .ratio(col_ratio),
    .count(cols_c), .loc(cloc));
  bgr_locate u_row (
    .clk(clk), .en(adv), .t(s_axis_tdata[67:58]), .ratio(row_ratio),
    .count(rows_c), .loc(rloc));

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd1  <= s_axis_tuser;
      out1  <= s_axis_tdata[57:48] >= tgt_cols[9:0] && tgt_cols[10] == 1'b0 ||
               s_axis_tdata[67:58] >= tgt_rows[9:0] && tgt_rows[10] == 1'b0;
      addr1 <= s_axis_tdata[15:0];
      val1  <= s_axis_tdata[47:16];
      cmd2  <= cmd1;
      out2  <= out1;
      addr2 <= addr1;
      val2  <= val1;
    end
  end

  // stage 3: addresses of the four neighbors
  logic [2*IW-1:0] up3;
  logic [AW:0]     up3a, lo3a;
  logic [IW-1:0]   ci3;
  logic [FracWidth-1:0] dx3, dy4, dy3, dy5;
  logic [15:0]     addr3;
  logic signed [31:0] val3;

  always_ff @(posedge clk) begin
    if (adv) begin
      up3   <= rloc.idx * cols_c + (2*IW)'(cloc.idx);
      ci3   <= cloc.idx;
      dx3   <= cloc.frac;
      dy3   <= rloc.frac;
      cmd3  <= cmd2;
      out3  <= out2;
      addr3 <= addr2;
      val3  <= val2;
    end
  end

  // neighbors up-1, up, lo-1, lo: each pair holds one even and one odd
  // address, so each pair reads from its own even/odd split copy
  assign up3a = (AW+1)'(up3);
  assign lo3a = up3a - (AW+1)'(cols_c);

  logic [AW-1:0] ua, ub, la, lb; // up-1, up, lo-1, lo
  assign ua = AW'(up3a - 1'b1);
  assign ub = AW'(up3a);
  assign la = AW'(lo3a - 1'b1);
  assign lb = AW'(lo3a);

  // saturate a loaded sample to SAMPLE_WIDTH
  logic signed [SW-1:0] ld_sat;
  always_comb begin
    if (SW >= 32) ld_sat = SW'(val3);
    else if ((SW+33)'(val3) > (SW+33)'(SatHi)) ld_sat = SW'(SatHi);
    else if ((SW+33)'(val3) < (SW+33)'(SatLo)) ld_sat = SW'(SatLo);
    else ld_sat = SW'(val3);
  end

  // two copies (upper pair, lower pair), each split even/odd: one write
  // port and one read port per bank
  logic signed [SW-1:0] mem_ue [Depth/2];
  logic signed [SW-1:0] mem_uo [Depth/2];
  logic signed [SW-1:0] mem_le [Depth/2];
  logic signed [SW-1:0] mem_lo [Depth/2];
  logic signed [SW-1:0] rd_ue, rd_uo, rd_le, rd_lo;
  logic ua_odd4, la_odd4;
  logic we;
  logic [AW-1:0] wa;
  logic [AW-1:0] ue_a, uo_a, le_a, lo_a;

  assign we   = adv && vld[2] && cmd3 == CMD_LOAD && 32'(addr3) < 32'(Depth);
  assign wa   = AW'(addr3);
  assign ue_a = ua[0] ? ub : ua;
  assign uo_a = ua[0] ? ua : ub;
  assign le_a = la[0] ? lb : la;
  assign lo_a = la[0] ? la : lb;

  always_ff @(posedge clk) begin
    if (we && !wa[0]) begin
      mem_ue[wa[AW-1:1]] <= ld_sat;
      mem_le[wa[AW-1:1]] <= ld_sat;
    end
    if (we && wa[0]) begin
      mem_uo[wa[AW-1:1]] <= ld_sat;
      mem_lo[wa[AW-1:1]] <= ld_sat;
    end
    if (adv) begin
      rd_ue   <= mem_ue[ue_a[AW-1:1]];
      rd_uo   <= mem_uo[uo_a[AW-1:1]];
      rd_le   <= mem_le[le_a[AW-1:1]];
      rd_lo   <= mem_lo[lo_a[AW-1:1]];
      ua_odd4 <= ua[0];
      la_odd4 <= la[0];
      dy4     <= dy3;
      cmd4    <= cmd3;
      out4    <= out3;
    end
  end

  // stage 5: column blends
  logic signed [SW-1:0] f11, f21, f12, f22;
  logic [FracWidth-1:0] dx4;
  always_ff @(posedge clk) begin
    if (adv) dx4 <= dx3;
  end
  assign f12 = ua_odd4 ? rd_uo : rd_ue;
  assign f22 = ua_odd4 ? rd_ue : rd_uo;
  assign f11 = la_odd4 ? rd_lo : rd_le;
  assign f21 = la_odd4 ? rd_le : rd_lo;

  logic signed [SW:0] low_row, high_row;
  bgr_blend #(.W(SW)) u_bl_lo (.clk(clk), .en(adv), .a(f11), .b(f21), .w(dx4),
                               .y(low_row));
  bgr_blend #(.W(SW)) u_bl_hi (.clk(clk), .en(adv), .a(f12), .b(f22), .w(dx4),
                               .y(high_row));
  always_ff @(posedge clk) begin
    if (adv) begin
      dy5  <= dy4;
      cmd5 <= cmd4;
      out5 <= out4;
      cmd6 <= cmd5;
    end
  end

  // stage 7/8: row blend, saturate (blend unit adds its own stage)
  logic signed [SW+1:0] v7;
  logic signed [SW:0]   vs;
  logic                 out6, out7, out8;
  logic [FracWidth-1:0] dy6;
  bgr_blend #(.W(SW+1)) u_bl_row (.clk(clk), .en(adv), .a(low_row), .b(high_row),
                                  .w(dy6), .y(v7));
  always_ff @(posedge clk) begin
    if (adv) begin
      dy6  <= dy5;
      out6 <= out5;
      out7 <= out6;
      out8 <= out7;
      cmd7 <= cmd6;
      cmd8 <= cmd7;
    end
  end

  always_comb begin
    if (v7 > (SW+2)'(SatHi)) vs = SatHi;
    else if (v7 < (SW+2)'(SatLo)) vs = SatLo;
    else vs = (SW+1)'(v7);
  end

  // the row blend output register is the output register; vld[7] marks it
  logic signed [31:0] vq;
  always_comb begin
    if ((SW+33)'(vs) > (SW+33)'(32'sh7FFF_FFFF)) vq = 32'sh7FFF_FFFF;
    else if ((SW+33)'(vs) < (SW+33)'(-33'sh8000_0000)) vq = 32'sh8000_0000;
    else vq = 32'(vs);
  end

  assign m_axis_tdata = out8 ? 32'd0 : vq;
  assign m_axis_tuser = out8;

`ifndef ASSERT_OFF
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output changed under stall");
  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 32'd0)
    else $error("outside cell with nonzero value");
  a_no_write_stall: assert property (@(posedge clk) disable iff (rst)
    we |-> adv)
    else $error("store write while stalled");
`endif
endmodule

FILE: rtl/bgr_locate.sv
// one axis: registered product, then index and fraction with edge clamps
module bgr_locate (
  input  logic                         clk,
  input  logic                         en,
  input  logic [9:0]                   t,
  input  logic [19:0]                  ratio,
  input  logic [bgr_pkg::IdxWidth-1:0] count,
  output bgr_pkg::axis_loc_t           loc
);
  import bgr_pkg::*;

  logic [PosWidth-1:0] p;
  logic [IdxWidth-1:0] count_q;
  logic [PosWidth-1:0] num;
  logic [PosWidth-18:0] i_raw;
  axis_loc_t           loc_next;
  logic [PosWidth-1:0] frac_w;

  always_ff @(posedge clk) begin
    if (en) begin
      p       <= PosWidth'({t, 1'b1}) * PosWidth'(ratio);
      count_q <= count;
      loc     <= loc_next;
    end
  end

  always_comb begin
    num    = p - HalfPos + PosWidth'(FracOne - 18'd1);
    i_raw  = num[PosWidth-1:17];
    frac_w = p + HalfPos - {i_raw, 17'd0};
    if (p <= HalfPos) begin
      loc_next.idx  = IdxWidth'(1);
      loc_next.frac = '0;
    end else if (i_raw >= (PosWidth-17)'(count_q)) begin
      loc_next.idx  = count_q - IdxWidth'(1);
      loc_next.frac = FracOne;
    end else begin
      loc_next.idx  = IdxWidth'(i_raw);
      loc_next.frac = frac_w[FracWidth-1:0];
    end
  end
endmodule

FILE: rtl/bgr_blend.sv
// a*(1-w) + b*w, rounded half up to q16.16, two register stages
module bgr_blend #(
  parameter int W = 32
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [W-1:0]            a,
  input  logic signed [W-1:0]            b,
  input  logic [bgr_pkg::FracWidth-1:0]  w,
  output logic signed [W:0]              y
);
  import bgr_pkg::*;

  localparam int PW = W + FracWidth + 2;
  logic signed [PW-1:0] pa, pb;
  logic signed [PW:0]   s;
  logic signed [PW:0]   x;

  always_ff @(posedge clk) begin
    if (en) begin
      pa <= PW'(a) * PW'($signed({1'b0, FracOne - w}));
      pb <= PW'(b) * PW'($signed({1'b0, w}));
      y  <= (W+1)'(x >>> 17);
    end
  end

  always_comb begin
    s = (PW+1)'(pa) + (PW+1)'(pb);
    x = s + (PW+1)'(65536);
  end
endmodule

FILE: verif/tb_bilinear_grid_resampler_unit.sv
`timescale 1ns / 100ps

module tb_bilinear_grid_resampler_unit;
  import bgr_pkg::*;

  localparam int StoreDepth = DefMaxSourceColumns * DefMaxSourceRows;
  localparam longint QOne = 131072;  // 1.0 in q1.17
  localparam longint QHalf = 65536;  // half a cell in 2^-17 units

  typedef struct {
    logic        command;
    logic [15:0] address;
    logic [31:0] sample;
    logic [9:0]  column;
    logic [9:0]  row;
  } grid_item_t;

  typedef struct {
    logic [31:0] value;
    logic        outside;
  } cell_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [CfgDataWidth-1:0] cfg_data = '0;

  bilinear_grid_resampler_unit DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow copy of the block's registers and source store
  int unsigned src_cols = 256, src_rows = 256, tgt_cols = 256, tgt_rows = 256;
  int unsigned col_ratio = 65536, row_ratio = 65536;
  logic [31:0] sample_store [0:StoreDepth-1];

  grid_item_t pending_items[$];
  cell_result_t expected_cells[$];
  grid_item_t shown_item;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  logic long_hold_req = 1'b0;
  logic long_hold_done = 1'b0;
  int hold_left = 0;

  // 4 ns clock; reset held high from the start, then released
  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  // hard stop in case the block hangs
  initial begin
    #4000000;
    $display("tb_bilinear_grid_resampler_unit failed");
    $finish;
  end

  function automatic int unsigned clamp_count(int unsigned c, int unsigned maxc);
    if (c < 2) return 2;
    if (c > maxc) return maxc;
    return c;
  endfunction

  // upper neighbor index and q1.17 fraction along one axis
  function automatic void find_neighbor(int unsigned t, int unsigned ratio,
                                        int unsigned count, output int unsigned idx,
                                        output longint frac);
    longint p, i;
    p = longint'(2 * t + 1) * longint'(ratio);
    if (p <= QHalf) begin
      idx = 1;
      frac = 0;
      return;
    end
    i = (p - QHalf + QOne - 1) >>> 17;
    if (i >= count) begin
      // high edge clamp
      idx = count - 1;
      frac = QOne;
    end else begin
      idx = int'(i);
      frac = p + QHalf - i * QOne;
    end
  endfunction

  // weighted sum rounded half up back to q16.16
  function automatic longint mix_pair(longint a, longint b, longint w);
    longint x;
    x = a * (QOne - w) + b * w + 65536;
    if (x >= 0) return x >>> 17;
    return -(((-x) + 131071) >>> 17);
  endfunction

  function automatic longint stored(int unsigned addr);
    return longint'($signed(sample_store[addr]));
  endfunction

  function automatic cell_result_t interpolate_cell(int unsigned tc, int unsigned tr);
    cell_result_t r;
    int unsigned cols, rows, ci, ri, up, lo;
    longint dx, dy, low_row, high_row, v;
    r.value = '0;
    r.outside = 1'b1;
    if (tc >= tgt_cols || tr >= tgt_rows) return r;
    cols = clamp_count(src_cols, DefMaxSourceColumns);
    rows = clamp_count(src_rows, DefMaxSourceRows);
    find_neighbor(tc, col_ratio, cols, ci, dx);
    find_neighbor(tr, row_ratio, rows, ri, dy);
    up = ri * cols + ci;
    lo = up - cols;
    low_row = mix_pair(stored(lo - 1), stored(lo), dx);
    high_row = mix_pair(stored(up - 1), stored(up), dx);
    v = mix_pair(low_row, high_row, dy);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    r.value = v[31:0];
    r.outside = 1'b0;
    return r;
  endfunction

  // source side: presents queued items, holds each until taken
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (shown_item.command == CMD_LOAD) sample_store[shown_item.address] = shown_item.sample;
        else expected_cells = {expected_cells,
                               interpolate_cell(shown_item.column, shown_item.row)};
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          shown_item = pending_items.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser <= shown_item.command;
          s_axis_tdata <= {4'b0, shown_item.row, shown_item.column, shown_item.sample,
                           shown_item.address};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted on its own
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      long_hold_done <= 1'b0;
    end else if (long_hold_req && !long_hold_done) begin
      hold_left <= 400;
      long_hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result side: check against the oldest expected cell, stall at random
  always @(posedge clk) begin
    cell_result_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_cells.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result item: value %h outside %b", m_axis_tdata, m_axis_tuser);
        end else begin
          want = expected_cells.pop_front();
          if (m_axis_tdata !== want.value || m_axis_tuser !== want.outside) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected value %h outside %b, got value %h outside %b",
                       want.value, want.outside, m_axis_tdata, m_axis_tuser);
          end
        end
      end
      m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic push_load(int unsigned addr, logic [31:0] value);
    grid_item_t it;
    it.command = CMD_LOAD;
    it.address = addr[15:0];
    it.sample = value;
    it.column = 10'($urandom);
    it.row = 10'($urandom);
    pending_items = {pending_items, it};
  endtask

  task automatic push_query(int unsigned tc, int unsigned tr);
    grid_item_t it;
    it.command = CMD_QUERY;
    it.address = 16'($urandom);
    it.sample = $urandom;
    it.column = tc[9:0];
    it.row = tr[9:0];
    pending_items = {pending_items, it};
  endtask

  // loads the four neighbors of one target cell, then queries it
  task automatic push_covered_query(int unsigned tc, int unsigned tr);
    int unsigned cols, rows, ci, ri, up;
    longint dx, dy;
    cols = clamp_count(src_cols, DefMaxSourceColumns);
    rows = clamp_count(src_rows, DefMaxSourceRows);
    find_neighbor(tc, col_ratio, cols, ci, dx);
    find_neighbor(tr, row_ratio, rows, ri, dy);
    up = ri * cols + ci;
    push_load(up - cols - 1, $urandom);
    push_load(up - cols, $urandom);
    push_load(up - 1, $urandom);
    push_load(up, $urandom);
    push_query(tc, tr);
  endtask

  // quiet: no item waiting, none expected, pipe drained of loads too
  task automatic wait_quiet();
    do @(posedge clk); while (pending_items.size() > 0 || s_axis_tvalid ||
                               expected_cells.size() > 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CfgDataWidth-1:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SOURCE_COLUMNS: src_cols = value & 'h1FF;
      REG_SOURCE_ROWS:    src_rows = value & 'h1FF;
      REG_TARGET_COLUMNS: tgt_cols = value & 'h7FF;
      REG_TARGET_ROWS:    tgt_rows = value & 'h7FF;
      REG_COLUMN_RATIO:   col_ratio = value & 'hFFFFF;
      REG_ROW_RATIO:      row_ratio = value & 'hFFFFF;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // program all registers once the block is quiet
  task automatic program_grid(int unsigned sc, int unsigned sr, int unsigned tc,
                              int unsigned tr, int unsigned cr, int unsigned rr);
    wait_quiet();
    write_reg(REG_SOURCE_COLUMNS, sc);
    write_reg(REG_SOURCE_ROWS, sr);
    write_reg(REG_TARGET_COLUMNS, tc);
    write_reg(REG_TARGET_ROWS, tr);
    write_reg(REG_COLUMN_RATIO, cr);
    write_reg(REG_ROW_RATIO, rr);
  endtask

  // new grid: program all registers, then fill every entry a query can reach
  task automatic start_grid(int unsigned sc, int unsigned sr, int unsigned tc,
                            int unsigned tr, int unsigned cr, int unsigned rr);
    int unsigned n;
    program_grid(sc, sr, tc, tr, cr, rr);
    n = clamp_count(src_cols, DefMaxSourceColumns) * clamp_count(src_rows, DefMaxSourceRows);
    for (int unsigned a = 0; a < n; a++) push_load(a, $urandom);
  endtask

  // mostly in-range queries, some cells past the target edge, some reloads
  task automatic push_random(int count);
    int unsigned cells;
    cells = clamp_count(src_cols, DefMaxSourceColumns) * clamp_count(src_rows, DefMaxSourceRows);
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(9))
        0: push_load($urandom_range(cells - 1), $urandom);
        1: push_load($urandom_range(65535), $urandom);
        2: push_query($urandom_range(1023), $urandom_range(1023));
        default: push_query($urandom_range(tgt_cols > 1024 ? 1023 : tgt_cols - 1),
                            $urandom_range(tgt_rows > 1024 ? 1023 : tgt_rows - 1));
      endcase
    end
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
      default: begin send_idle_pct = 23; recv_stall_pct = 23; end
    endcase
  endtask

  initial begin
    @(negedge rst);
    @(posedge clk);

    // directed: 4x4 grid at half ratio, extreme samples in two corners and two inner cells
    start_grid(4, 4, 8, 8, 32768, 32768);
    push_load(0, 32'h7FFF_FFFF);
    push_load(3, 32'h8000_0000);
    push_load(12, 32'hFFFF_FFFF);
    push_load(15, 32'h0000_0000);
    push_load(5, 32'h7FFF_FFFF);
    push_load(6, 32'h7FFF_FFFF);
    push_query(0, 0);       // low edge clamp
    push_query(7, 7);       // high edge clamp
    push_query(7, 0);
    push_query(0, 7);
    push_query(3, 4);
    push_query(8, 0);       // past the target width
    push_query(0, 8);       // past the target height
    push_query(1023, 1023);

    // zero ratio on a source size below two, single target cell
    start_grid(1, 0, 1, 1, 0, 0);
    push_query(0, 0);
    push_query(1, 0);
    push_query(0, 1);

    // widest source (oversize value), largest target and ratio;
    // only the neighbors of each queried cell are loaded
    program_grid(511, 2, 1024, 1024, 1048575, 1048575);
    push_covered_query(0, 0);
    push_covered_query(1023, 1023);
    push_covered_query(512, 3);

    // tallest source
    program_grid(2, 256, 1, 1024, 65536, 16384);
    push_covered_query(0, 1023);
    push_covered_query(0, 0);

    // random phases, each idling pattern in turn
    for (int ph = 0; ph < 8; ph++) begin
      start_grid($urandom_range(2, 10), $urandom_range(2, 10), $urandom_range(1, 40),
                 $urandom_range(1, 40), $urandom_range(0, 262143), $urandom_range(0, 262143));
      set_idling(ph % 4);
      push_random(55);
    end

    // receiver holds off for a long stretch while the sender keeps offering
    wait_quiet();
    set_idling(0);
    push_random(150);
    long_hold_req <= 1'b1;
    wait_quiet();
    set_idling(3);
    push_random(60);

    wait_quiet();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_cells.size() == 0) begin
      $display("tb_bilinear_grid_resampler_unit passed");
    end else begin
      $display("tb_bilinear_grid_resampler_unit failed");
    end
    $finish;
  end

endmodule
